@@ src/mpos_pkg.sv @@
// shared types, constants and helper functions of the m-sequence product offset search
// no dependencies; imported by every module of the block
package mpos_pkg;

  localparam int MAX_BITS    = 10;
  localparam int MIN_BITS    = 2;
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int VAL_W       = 10;
  localparam int OFF_W       = 11;
  localparam int CFG_W       = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

  // input selector codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_TGT,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } mpos_state_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_OFF_A,
    RD_OFF_B,
    RD_SCAN
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    accept_load;
    logic    accept_query;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch_a;
    logic    latch_tgt;
    logic    scan_step;
    logic    load_out;
  } mpos_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic scan_last;
    logic out_free;
  } mpos_sts_t;

  typedef struct packed {
    logic             bad;
    logic [IDX_W-1:0] pos;
  } adj_t;

  // period 2^n - 1 with n clamped to the supported range
  function automatic logic [IDX_W-1:0] period_of(input logic [CFG_W-1:0] bits);
    logic [CFG_W-1:0] n;
    logic [IDX_W:0]   p;
    n = bits;
    if (bits < CFG_W'(MIN_BITS)) n = CFG_W'(MIN_BITS);
    if (bits > CFG_W'(MAX_BITS)) n = CFG_W'(MAX_BITS);
    p = ((IDX_W+1)'(1) << n) - (IDX_W+1)'(1);
    return p[IDX_W-1:0];
  endfunction

  // negative offsets wrap once by the period, then range check
  function automatic adj_t adjust(input logic [OFF_W-1:0] off,
                                  input logic [IDX_W-1:0] period);
    logic [OFF_W:0] v;
    adj_t           r;
    v = {off[OFF_W-1], off} +
        (off[OFF_W-1] ? {{(OFF_W+1-IDX_W){1'b0}}, period} : '0);
    r.bad = v[OFF_W] || (v[OFF_W-1:0] >= {{(OFF_W-IDX_W){1'b0}}, period});
    r.pos = v[IDX_W-1:0];
    return r;
  endfunction

endpackage

@@ src/msequence_product_offset_search_unit.sv @@
// top level of the m-sequence product offset search
// depends on mpos_pkg, mpos_ctrl and mpos_dp

// A load request (tuser 0) writes one table entry and is ignored when its index is not below
// the period 2^sequence_bits - 1. A query request (tuser 1) wraps negative offsets by the
// period, XORs the two addressed table entries and scans the table once over the period, one
// entry per cycle through the single table read port. The answer is the largest matching
// index. A finished result waits in an output register while the next request is taken. The
// table has no reset: load all period entries before the first query. sequence_bits is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while idle, as the block
// does not enforce this. Values below 2 act as 2 and above 10 act as 10.
module msequence_product_offset_search_unit import mpos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,  // sequence_bits
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[9:0], entry_value[19:10], offset_a[30:20], offset_b[41:31], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,     // func
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // found[0], found_index[10:1], bad_offset[11], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  mpos_cmd_t cmd;
  mpos_sts_t sts;

  mpos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpos_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .entry_index (in_tdata[IDX_W-1:0]),
    .entry_value (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .offset_a    (in_tdata[IDX_W+VAL_W+OFF_W-1:IDX_W+VAL_W]),
    .offset_b    (in_tdata[IDX_W+VAL_W+2*OFF_W-1:IDX_W+VAL_W+OFF_W]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ src/mpos_ctrl.sv @@
// controller state machine: sequences table reads, the scan and the result request
// depends on mpos_pkg
module mpos_ctrl import mpos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_func,
  output logic      in_tready,
  input  mpos_sts_t sts,
  output mpos_cmd_t cmd
);

  mpos_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_func == FUNC_QUERY) state_nxt = ST_RD_A;
      end
      ST_RD_A: begin
        state_nxt = sts.bad ? ST_EMIT : ST_RD_B;
      end
      ST_RD_B:  state_nxt = ST_TGT;
      ST_TGT:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready        = 1'b0;
    cmd              = '0;
    cmd.rd_sel       = RD_OFF_A;
    case (state_r)
      ST_IDLE: begin
        in_tready        = 1'b1;
        cmd.accept_load  = in_tvalid && in_func == FUNC_LOAD;
        cmd.accept_query = in_tvalid && in_func == FUNC_QUERY;
      end
      ST_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_OFF_A;
      end
      ST_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_OFF_B;
        cmd.latch_a = 1'b1;
      end
      ST_TGT: begin
        cmd.latch_tgt = 1'b1;
      end
      ST_SCAN: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_SCAN;
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/mpos_dp.sv @@
// datapath: config register, state table memory, offset adjust, scan compare, output register
// depends on mpos_pkg
module mpos_dp import mpos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [VAL_W-1:0]      entry_value,
  input  logic [OFF_W-1:0]      offset_a,
  input  logic [OFF_W-1:0]      offset_b,
  input  mpos_cmd_t             cmd,
  output mpos_sts_t             sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CFG_W-1:0] bits_r;
  logic [IDX_W-1:0] period;
  logic [VAL_W-1:0] mem [TABLE_DEPTH];
  logic [VAL_W-1:0] rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] pos_a_r, pos_b_r;
  logic             bad_r;
  logic [VAL_W-1:0] a_val_r, target_r;
  logic [IDX_W-1:0] scan_addr_r, cmp_idx_r;
  logic             cmp_vld_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  adj_t             adj_a, adj_b;
  logic             load_ok;

  assign period  = period_of(bits_r);
  assign adj_a   = adjust(offset_a, period);
  assign adj_b   = adjust(offset_b, period);
  assign load_ok = cmd.accept_load && (entry_index < period);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      bits_r <= cfg_wr_data;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_OFF_A: rd_addr = pos_a_r;
      RD_OFF_B: rd_addr = pos_b_r;
      RD_SCAN:  rd_addr = scan_addr_r;
      default:  rd_addr = pos_a_r;
    endcase
  end

  // state table, one write and one registered read
  always_ff @(posedge clk) begin
    if (load_ok) mem[entry_index] <= entry_value;
    if (cmd.rd_en) rd_r <= mem[rd_addr];
  end

  // query capture and product target
  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      pos_a_r <= adj_a.pos;
      pos_b_r <= adj_b.pos;
      bad_r   <= adj_a.bad || adj_b.bad;
    end
    if (cmd.latch_a) a_val_r <= rd_r;
    if (cmd.latch_tgt) target_r <= a_val_r ^ rd_r;
  end

  // scan counter and compare pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch_tgt) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_step) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
    end
    cmp_idx_r <= scan_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
    end
  end

  // hit tracking, later indices overwrite earlier ones
  always_ff @(posedge clk) begin
    if (cmd.latch_tgt) begin
      hit_r     <= 1'b0;
      hit_idx_r <= '0;
    end else if (cmp_vld_r && rd_r == target_r) begin
      hit_r     <= 1'b1;
      hit_idx_r <= cmp_idx_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (bad_r) begin
        out_data_r <= {{(OUT_DATA_W-IDX_W-2){1'b0}}, 1'b1, {IDX_W{1'b0}}, 1'b0};
      end else begin
        out_data_r <= {{(OUT_DATA_W-IDX_W-2){1'b0}}, 1'b0, hit_idx_r, hit_r};
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign sts.bad       = bad_r;
  assign sts.scan_last = (scan_addr_r == period - IDX_W'(1));
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule
